// File: design/grid_ray_cast_bresenham_top_assert.svh
// ----------------------------------------------------------------------------
// Ray caster assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CAST_BRESENHAM_TOP_ASSERT_SVH
`define GRID_RAY_CAST_BRESENHAM_TOP_ASSERT_SVH

// same-cycle implication
`define GRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/grc_pkg.sv
// ----------------------------------------------------------------------------
// Ray caster package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned GridDimDefault = 256;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [8:0]        CfgWidthReset  = 9'd256;
  localparam logic [8:0]        CfgHeightReset = 9'd256;
  localparam logic signed [7:0] CfgThreshReset = 8'sd50;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth  = 2'd0,
    CfgGridHeight = 2'd1,
    CfgOccThresh  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpWrite = 1'b0,
    OpCast  = 1'b1
  } op_e;

  // cell coordinate, covers -1 .. 256
  typedef logic signed [9:0]  coord_t;
  // Bresenham error term
  typedef logic signed [10:0] berr_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    logic   last;
  } walk_cell_t;

endpackage

// File: design/grc_if.sv
// ----------------------------------------------------------------------------
// Ray caster channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface grc_req_if import grc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        cell_x;
  logic [7:0]        cell_y;
  logic signed [7:0] cell_value;
  logic [7:0]        target_x;
  logic [7:0]        target_y;

  modport source (output valid, operation, cell_x, cell_y, cell_value, target_x, target_y,
                  input ready);
  modport sink (input valid, operation, cell_x, cell_y, cell_value, target_x, target_y,
                output ready);
endinterface

interface grc_rsp_if import grc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t end_x;
  coord_t end_y;
  logic   blocked;

  modport source (output valid, end_x, end_y, blocked, input ready);
  modport sink (input valid, end_x, end_y, blocked, output ready);
endinterface

interface grc_cfg_if import grc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/grc_line_walk.sv
// ----------------------------------------------------------------------------
// Ray caster line walker
// Bresenham stepper: set up from start/target, yields one cell per step,
// axes restored for steep lines, flags the cell one past the target.
// ----------------------------------------------------------------------------
module grc_line_walk import grc_pkg::*; (
  input  logic       clk_i,
  input  logic       start_i,
  input  logic       step_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] target_x_i,
  input  logic [7:0] target_y_i,
  output walk_cell_t cell_o
);

  coord_t     a_q, a_d, b_q, b_d, a_end_q, a_end_d;
  berr_t      err_q, err_d;
  logic [7:0] da_q, da_d, db_q, db_d;
  logic       a_up_q, a_up_d, b_up_q, b_up_d, steep_q, steep_d;

  coord_t     sx, sy, tx, ty, dx, dy, a0, b0, a1, b1;
  logic [7:0] adx, ady;
  berr_t      err_sum;
  logic       bump;

  always_comb begin
    sx  = $signed({2'b00, start_x_i});
    sy  = $signed({2'b00, start_y_i});
    tx  = $signed({2'b00, target_x_i});
    ty  = $signed({2'b00, target_y_i});
    dx  = tx - sx;
    dy  = ty - sy;
    adx = dx[9] ? 8'(-dx) : 8'(dx);
    ady = dy[9] ? 8'(-dy) : 8'(dy);

    steep_d = ady > adx;
    a0      = steep_d ? sy : sx;
    b0      = steep_d ? sx : sy;
    a1      = steep_d ? ty : tx;
    b1      = steep_d ? tx : ty;
    da_d    = steep_d ? ady : adx;
    db_d    = steep_d ? adx : ady;
    a_up_d  = a0 < a1;
    b_up_d  = b0 < b1;
    a_end_d = a_up_d ? a1 + 10'sd1 : a1 - 10'sd1;

    err_sum = err_q + $signed({3'b000, db_q});
    bump    = $signed({err_sum, 1'b0}) >= $signed({4'b0000, da_q});

    a_d   = a_q;
    b_d   = b_q;
    err_d = err_q;
    if (start_i) begin
      a_d   = a0;
      b_d   = b0;
      err_d = '0;
    end else if (step_i) begin
      a_d   = a_up_q ? a_q + 10'sd1 : a_q - 10'sd1;
      b_d   = bump ? (b_up_q ? b_q + 10'sd1 : b_q - 10'sd1) : b_q;
      err_d = bump ? err_sum - $signed({3'b000, da_q}) : err_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    err_q <= err_d;
    if (start_i) begin
      da_q    <= da_d;
      db_q    <= db_d;
      a_up_q  <= a_up_d;
      b_up_q  <= b_up_d;
      steep_q <= steep_d;
      a_end_q <= a_end_d;
    end
  end

  assign cell_o.cx   = steep_q ? b_q : a_q;
  assign cell_o.cy   = steep_q ? a_q : b_q;
  assign cell_o.last = a_q == a_end_q;

endmodule

// File: design/grid_ray_cast_bresenham_top.sv
// ----------------------------------------------------------------------------
// Occupancy-grid ray caster
// Grid cells live in one synchronous memory; a cast walks a Bresenham line,
// one cell per cycle, to the first off-grid or occupied cell, else the target.
// ----------------------------------------------------------------------------
//  port   | dir | beat contents
//  -------+-----+--------------------------------------------------------
//  req_i  | in  | operation, cell_x, cell_y, cell_value, target_x, target_y
//  rsp_o  | out | end_x, end_y, blocked (one beat per cast)
//  cfg_i  | in  | index, data (grid_width, grid_height, occupied_threshold)
//
//  Cast: checks up to max(|dx|,|dy|)+2 cells, one cell per cycle, bounded by the
//  single grid memory read port.
//  Reset clears control and config only; grid contents are undefined until written.
//  req_i stalls while a cast runs or its result waits for the result register.
// ----------------------------------------------------------------------------
module grid_ray_cast_bresenham_top import grc_pkg::*; #(
  parameter int unsigned GRID_DIM = GridDimDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  grc_cfg_if.sink   cfg_i,
  grc_req_if.sink   req_i,
  grc_rsp_if.source rsp_o
);

  localparam int unsigned Depth = GRID_DIM * GRID_DIM;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [13:0] DimL  = 14'(GRID_DIM);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StHold = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [8:0]        cfg_w_q, cfg_h_q;
  logic signed [7:0] cfg_thr_q;

  logic signed [7:0] grid_mem_q [Depth];
  logic signed [7:0] rd_data_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              mem_we;

  walk_cell_t walk_pos;
  logic       walk_start, walk_step, cell_inb;
  logic       issue_done_q, issue_done_d;

  logic   p_vld_q, p_vld_d, p_inb_q, p_last_q;
  coord_t p_cx_q, p_cy_q;
  logic   chk_stop, chk_done;

  logic [7:0] tgt_x_q, tgt_y_q;
  coord_t     res_x_q, res_y_q;
  logic       res_blk_q;

  logic   out_vld_q, out_vld_d, out_free;
  coord_t end_x_q, end_y_q;
  logic   blk_q;

  logic req_fire, cast_fire;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= CfgWidthReset;
      cfg_h_q   <= CfgHeightReset;
      cfg_thr_q <= CfgThreshReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgGridWidth:  cfg_w_q   <= cfg_i.data;
        CfgGridHeight: cfg_h_q   <= cfg_i.data;
        CfgOccThresh:  cfg_thr_q <= $signed(cfg_i.data[7:0]);
        default: ;
      endcase
    end
  end

  // request side
  assign req_i.ready = state_q == StIdle;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cast_fire   = req_fire && (req_i.operation == OpCast);
  assign walk_start  = cast_fire;
  assign walk_step   = (state_q == StWalk) && !issue_done_q;

  assign mem_we  = req_fire && (req_i.operation == OpWrite) &&
                   (14'(req_i.cell_x) < DimL) && (14'(req_i.cell_y) < DimL);
  assign wr_addr = AW'(AW'(req_i.cell_y) * AW'(GRID_DIM) + AW'(req_i.cell_x));

  grc_line_walk u_walk (
    .clk_i      (clk_i),
    .start_i    (walk_start),
    .step_i     (walk_step),
    .start_x_i  (req_i.cell_x),
    .start_y_i  (req_i.cell_y),
    .target_x_i (req_i.target_x),
    .target_y_i (req_i.target_y),
    .cell_o     (walk_pos)
  );

  assign cell_inb = !walk_pos.cx[9] && !walk_pos.cy[9] &&
                    (walk_pos.cx[8:0] < cfg_w_q) && (walk_pos.cy[8:0] < cfg_h_q) &&
                    (14'(walk_pos.cx[8:0]) < DimL) && (14'(walk_pos.cy[8:0]) < DimL);
  assign rd_addr  = cell_inb ?
                    AW'(AW'(walk_pos.cy[8:0]) * AW'(GRID_DIM) + AW'(walk_pos.cx[8:0])) : '0;

  // grid memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[wr_addr] <= req_i.cell_value;
    end
    rd_data_q <= grid_mem_q[rd_addr];
  end

  // check stage
  assign chk_stop = p_vld_q && (!p_inb_q || (rd_data_q > cfg_thr_q));
  assign chk_done = (state_q == StWalk) && p_vld_q && (chk_stop || p_last_q);
  assign p_vld_d  = walk_step && !chk_done;

  always_comb begin
    issue_done_d = issue_done_q;
    if (walk_start) begin
      issue_done_d = 1'b0;
    end else if (walk_step && walk_pos.last) begin
      issue_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_step) begin
      p_cx_q   <= walk_pos.cx;
      p_cy_q   <= walk_pos.cy;
      p_inb_q  <= cell_inb;
      p_last_q <= walk_pos.last;
    end
    if (cast_fire) begin
      tgt_x_q <= req_i.target_x;
      tgt_y_q <= req_i.target_y;
    end
    if (chk_done) begin
      res_x_q   <= chk_stop ? p_cx_q : $signed({2'b00, tgt_x_q});
      res_y_q   <= chk_stop ? p_cy_q : $signed({2'b00, tgt_y_q});
      res_blk_q <= chk_stop;
    end
  end

  // control
  assign out_free = !out_vld_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cast_fire) state_d = StWalk;
      StWalk: if (chk_done) state_d = StHold;
      StHold: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if ((state_q == StHold) && out_free) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      issue_done_q <= 1'b0;
      p_vld_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      p_vld_q      <= p_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if ((state_q == StHold) && out_free) begin
      end_x_q <= res_x_q;
      end_y_q <= res_y_q;
      blk_q   <= res_blk_q;
    end
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.end_x   = end_x_q;
  assign rsp_o.end_y   = end_y_q;
  assign rsp_o.blocked = blk_q;

  `include "grid_ray_cast_bresenham_top_assert.svh"

  `GRC_ASSERT_NOW(a_pipe_only_walk, p_vld_q, state_q == StWalk, "check beat outside walk")
  `GRC_ASSERT_NEXT(a_last_ends_walk, (state_q == StWalk) && p_vld_q && p_last_q,
                   state_q == StHold, "walk ran past its last cell")
  `GRC_ASSERT_NEXT(a_cast_starts_clean, cast_fire,
                   (state_q == StWalk) && !p_vld_q && !issue_done_q, "cast start not clean")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray caster testbench
// Streams grid writes and ray casts through the request channel in bursts,
// stalls the result channel, and checks every result beat in order against a
// Bresenham walk over a shadow copy of the grid. Rays are planned so that
// every in-grid cell they read has been written first. The run steps through
// several register settings: zero, oversized and tiny grids, and both
// threshold extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import grc_pkg::*;

  localparam int GridDim     = 256;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 250;
  localparam int SettleCyc   = 12;
  localparam int CycleLimit  = 4000000;

  typedef struct {
    op_e               op;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic signed [7:0] cell_value;
    logic [7:0]        target_x;
    logic [7:0]        target_y;
  } ray_req_t;

  typedef struct {
    coord_t end_x;
    coord_t end_y;
    logic   blocked;
  } ray_end_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  grc_cfg_if cfg_if ();
  grc_req_if req_if ();
  grc_rsp_if rsp_if ();

  grid_ray_cast_bresenham_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // register copies, shared by planning and prediction
  logic [8:0]        cfg_width  = CfgWidthReset;
  logic [8:0]        cfg_height = CfgHeightReset;
  logic signed [7:0] cfg_thresh = CfgThreshReset;

  // grid as seen by accepted beats, and as planned by the stimulus
  logic signed [7:0] occ_grid   [GridDim*GridDim];
  logic signed [7:0] plan_grid  [GridDim*GridDim];
  bit                plan_known [GridDim*GridDim];

  ray_req_t cell_reqs [$];
  ray_end_t ray_ends  [$];

  ray_req_t on_wire;
  ray_end_t want;
  int       burst_left, gap_left;
  logic [31:0] stall_pat;
  logic [4:0]  stall_age;
  int       cycle_cnt;
  int       mismatches, queued_items, writes_done, casts_done, results_seen;
  int       blocked_seen, edge_seen;
  int       p_gap;
  coord_t   p_x, p_y;
  bit       p_hit;

  int phase_w [NumPhases] = '{256, 16, 0, 511, 1, 37, 256, 256};
  int phase_h [NumPhases] = '{256, 16, 256, 300, 1, 200, 256, 9};
  int phase_t [NumPhases] = '{50, 0, 50, -128, 127, 20, 127, -20};

  function automatic int clip8(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Bresenham walk; from_plan stops at the first unwritten in-grid cell
  function automatic void trace_ray(input int sx, input int sy, input int tx, input int ty,
                                    input bit from_plan, output coord_t ex, output coord_t ey,
                                    output bit hit, output int gap_addr);
    int a0, b0, a1, b1, a, b, da, db, astep, bstep, err, cx, cy, w, h, addr;
    bit steep, done;
    logic signed [7:0] v;
    w = (cfg_width > 9'd256) ? 256 : int'(cfg_width);
    h = (cfg_height > 9'd256) ? 256 : int'(cfg_height);
    steep = ((ty > sy ? ty - sy : sy - ty) > (tx > sx ? tx - sx : sx - tx));
    if (steep) begin
      a0 = sy; b0 = sx; a1 = ty; b1 = tx;
    end else begin
      a0 = sx; b0 = sy; a1 = tx; b1 = ty;
    end
    da = (a1 > a0) ? a1 - a0 : a0 - a1;
    db = (b1 > b0) ? b1 - b0 : b0 - b1;
    astep = (a0 < a1) ? 1 : -1;
    bstep = (b0 < b1) ? 1 : -1;
    a = a0;
    b = b0;
    err = 0;
    ex = coord_t'(tx);
    ey = coord_t'(ty);
    hit = 1'b0;
    gap_addr = -1;
    done = 1'b0;
    while (!done) begin
      cx = steep ? b : a;
      cy = steep ? a : b;
      if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
        ex = coord_t'(cx); ey = coord_t'(cy); hit = 1'b1; done = 1'b1;
      end else begin
        addr = cy * GridDim + cx;
        if (from_plan && !plan_known[addr]) begin
          gap_addr = addr;
          done = 1'b1;
        end else begin
          v = from_plan ? plan_grid[addr] : occ_grid[addr];
          if (v > cfg_thresh) begin
            ex = coord_t'(cx); ey = coord_t'(cy); hit = 1'b1; done = 1'b1;
          end
        end
      end
      if (!done) begin
        if (a == a1 + astep) begin
          done = 1'b1;
        end else begin
          a += astep;
          err += db;
          if (2 * err >= da) begin
            b += bstep;
            err -= da;
          end
        end
      end
    end
  endfunction

  task automatic queue_write(input int x, input int y, input logic signed [7:0] val);
    ray_req_t r;
    r.op = OpWrite;
    r.cell_x = x[7:0];
    r.cell_y = y[7:0];
    r.cell_value = val;
    r.target_x = $urandom;
    r.target_y = $urandom;
    plan_grid[y * GridDim + x] = val;
    plan_known[y * GridDim + x] = 1'b1;
    cell_reqs.push_back(r);
    queued_items++;
  endtask

  // writes every unknown cell the ray would read, then queues the cast
  task automatic queue_cast(input int sx, input int sy, input int tx, input int ty);
    ray_req_t r;
    coord_t ex, ey;
    bit hit;
    int gap, thr;
    logic signed [7:0] v;
    thr = cfg_thresh;
    trace_ray(sx, sy, tx, ty, 1'b1, ex, ey, hit, gap);
    while (gap >= 0) begin
      if (thr < 127 && $urandom_range(0, 99) < 15)
        v = thr + 1 + $urandom_range(0, 126 - thr);
      else
        v = -128 + $urandom_range(0, thr + 128);
      queue_write(gap % GridDim, gap / GridDim, v);
      trace_ray(sx, sy, tx, ty, 1'b1, ex, ey, hit, gap);
    end
    r.op = OpCast;
    r.cell_x = sx[7:0];
    r.cell_y = sy[7:0];
    r.cell_value = $urandom;
    r.target_x = tx[7:0];
    r.target_y = ty[7:0];
    cell_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic run_random(input int budget);
    int first, r, sx, sy, tx, ty, span, wl, hl, wx, wy;
    first = queued_items;
    wl = (cfg_width == 0) ? 1 : (cfg_width > 9'd256) ? 256 : int'(cfg_width);
    hl = (cfg_height == 0) ? 1 : (cfg_height > 9'd256) ? 256 : int'(cfg_height);
    wx = $urandom_range(0, (wl > 32) ? wl - 32 : 0);
    wy = $urandom_range(0, (hl > 32) ? hl - 32 : 0);
    while (queued_items - first < budget) begin
      if ($urandom_range(0, 99) < 10) begin
        queue_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end else begin
        if ($urandom_range(0, 1)) begin
          sx = clip8(wx + $urandom_range(0, 31));
          sy = clip8(wy + $urandom_range(0, 31));
        end else begin
          sx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, wl - 1);
          sy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hl - 1);
        end
        r = $urandom_range(0, 99);
        span = (r < 5) ? 0 : (r < 80) ? 6 : (r < 98) ? 30 : -1;
        if (span < 0) begin
          tx = $urandom_range(0, 255);
          ty = $urandom_range(0, 255);
        end else begin
          tx = clip8(sx + $urandom_range(0, 2 * span) - span);
          ty = clip8(sy + $urandom_range(0, 2 * span) - span);
        end
        queue_cast(sx, sy, tx, ty);
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [8:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CfgGridWidth:  cfg_width  = data;
      CfgGridHeight: cfg_height = data;
      default:       cfg_thresh = data[7:0];
    endcase
  endtask

  task automatic wait_drained();
    while (cell_reqs.size() != 0 || req_if.valid || ray_ends.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // request driver and grid predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      burst_left   <= 1;
      gap_left     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (on_wire.op == OpWrite) begin
          occ_grid[int'(on_wire.cell_y) * GridDim + int'(on_wire.cell_x)] = on_wire.cell_value;
          writes_done++;
        end else begin
          trace_ray(on_wire.cell_x, on_wire.cell_y, on_wire.target_x, on_wire.target_y,
                    1'b0, want.end_x, want.end_y, want.blocked, p_gap);
          ray_ends.push_back(want);
          casts_done++;
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || cell_reqs.size() == 0) begin
          req_if.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          on_wire = cell_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.operation  <= on_wire.op;
          req_if.cell_x     <= on_wire.cell_x;
          req_if.cell_y     <= on_wire.cell_y;
          req_if.cell_value <= on_wire.cell_value;
          req_if.target_x   <= on_wire.target_x;
          req_if.target_y   <= on_wire.target_y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // result stall pattern, redrawn whenever stall_age reaches its top value
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_pat    <= '1;
      stall_age    <= '0;
    end else begin
      rsp_if.ready <= stall_pat[0];
      if (stall_age == 5'd31) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= '1;
          1:       stall_pat <= $urandom;
          2:       stall_pat <= $urandom & $urandom;
          default: stall_pat <= $urandom | $urandom;
        endcase
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[31:1]};
      end
      stall_age <= stall_age + 5'd1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (rsp_if.blocked) blocked_seen++;
      if (rsp_if.end_x < 0 || rsp_if.end_x > 255 || rsp_if.end_y < 0 || rsp_if.end_y > 255)
        edge_seen++;
      if (ray_ends.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no cast outstanding, expected none, got (%0d,%0d) %0b",
                 $time, rsp_if.end_x, rsp_if.end_y, rsp_if.blocked);
      end else begin
        want = ray_ends.pop_front();
        if (rsp_if.end_x !== want.end_x) begin
          mismatches++;
          $display("%0t: end_x expected %0d, got %0d", $time, want.end_x, rsp_if.end_x);
        end
        if (rsp_if.end_y !== want.end_y) begin
          mismatches++;
          $display("%0t: end_y expected %0d, got %0d", $time, want.end_y, rsp_if.end_y);
        end
        if (rsp_if.blocked !== want.blocked) begin
          mismatches++;
          $display("%0t: blocked expected %0b, got %0b", $time, want.blocked, rsp_if.blocked);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d results still outstanding", $time, ray_ends.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int p;
    rst_ni            = 1'b0;
    cycle_cnt         = 0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CfgGridWidth;
    cfg_if.data       = '0;
    req_if.valid      = 1'b0;
    req_if.operation  = OpWrite;
    req_if.cell_x     = '0;
    req_if.cell_y     = '0;
    req_if.cell_value = '0;
    req_if.target_x   = '0;
    req_if.target_y   = '0;
    rsp_if.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_reg(CfgGridWidth, phase_w[p]);
      write_reg(CfgGridHeight, phase_h[p]);
      write_reg(CfgOccThresh, phase_t[p]);
      cfg_if.valid <= 1'b0;
      @(posedge clk_i);
      if (p == 0) begin
        queue_write(0, 0, 8'sd127);
        queue_write(255, 255, -8'sd128);
        queue_write(1, 1, 8'sd50);
        queue_write(2, 1, 8'sd51);
        queue_write(128, 64, -8'sd1);
        queue_write(85, 170, 8'sd85);
        queue_cast(1, 1, 1, 1);       // same cell: steps back onto the obstacle at origin
        queue_cast(0, 0, 0, 0);       // start cell occupied
        queue_cast(255, 255, 255, 255);
        queue_cast(1, 1, 3, 1);       // threshold itself passes, one above blocks
        queue_cast(250, 255, 255, 255); // overshoot past the right edge
        queue_cast(200, 3, 197, 0);   // overshoot past the top edge
        queue_cast(10, 10, 11, 14);   // steep, increasing
        queue_cast(40, 40, 37, 33);   // steep, decreasing
        queue_cast(60, 60, 64, 62);   // shallow
        queue_cast(128, 64, 126, 65);
      end
      run_random(PhaseItems);
    end
    wait_drained();

    $display("%0d writes and %0d casts over %0d register settings; %0d results checked",
             writes_done, casts_done, NumPhases, results_seen);
    $display("%0d rays blocked, %0d stopped off the storage edge", blocked_seen, edge_seen);
    if (mismatches == 0 && ray_ends.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
